[rtl/cmdb_pkg.sv]
// Types and constants shared by the CAN mailbox controller, datapath and top level.
// No dependencies.
`timescale 1ns / 1ps

package cmdb_pkg;

    localparam int ID_W      = 29;
    localparam int LEN_W     = 4;
    localparam int PAYLOAD_W = 64;
    localparam int SLOT_IN_W = 8;
    localparam int CFG_W     = 5;

    localparam logic [LEN_W-1:0] MAX_LEN = 4'd8;

    typedef enum logic [1:0] {
        CMD_SET   = 2'd0,
        CMD_FRAME = 2'd1,
        CMD_SWAP  = 2'd2,
        CMD_READ  = 2'd3
    } t_cmd_code;

    typedef struct packed {
        t_cmd_code              command;
        logic [SLOT_IN_W-1:0]   slot;
        logic [ID_W-1:0]        frame_id;
        logic [LEN_W-1:0]       frame_length;
        logic [PAYLOAD_W-1:0]   frame_payload;
    } t_in_item;

    typedef struct packed {
        logic [ID_W-1:0]        read_id;
        logic [LEN_W-1:0]       read_length;
        logic [PAYLOAD_W-1:0]   read_payload;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SEARCH,
        ST_RESP
    } t_mbx_state;

    // controller -> datapath
    typedef struct packed {
        logic capture;
        logic set_wr;
        logic probe;
        logic frame_wr;
        logic swap;
        logic bank_rd;
        logic out_load;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        t_cmd_code command;
        logic      slot_in_range;
        logic      idx_at_end;
        logic      hit;
        logic      out_free;
    } t_dp_stat;

endpackage

[rtl/cmdb_ctrl.sv]
// Sequencing state machine for the CAN mailbox.
// Depends on cmdb_pkg; drives the datapath through t_dp_cmd.
`timescale 1ns / 1ps

module cmdb_ctrl import cmdb_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_mbx_state r_state;
    t_mbx_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = (r_state != ST_IDLE);
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_DECODE;
                end
            end
            ST_DECODE: begin
                case (i_stat.command)
                    CMD_SET: begin
                        o_cmd.set_wr = i_stat.slot_in_range;
                        n_state      = ST_IDLE;
                    end
                    CMD_FRAME: begin
                        n_state = ST_SEARCH;
                    end
                    CMD_SWAP: begin
                        o_cmd.swap = 1'b1;
                        n_state    = ST_IDLE;
                    end
                    CMD_READ: begin
                        o_cmd.bank_rd = 1'b1;
                        n_state       = ST_RESP;
                    end
                    default: begin
                        n_state = ST_IDLE;
                    end
                endcase
            end
            ST_SEARCH: begin
                // one slot probed per cycle, compare runs on the registered probe result
                if (i_stat.hit) begin
                    o_cmd.frame_wr = 1'b1;
                    n_state        = ST_IDLE;
                end else if (i_stat.idx_at_end) begin
                    n_state = ST_IDLE;
                end else begin
                    o_cmd.probe = 1'b1;
                end
            end
            ST_RESP: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/cmdb_dp.sv]
// Datapath of the CAN mailbox: filter table, two frame banks, output register.
// Depends on cmdb_pkg; controlled by cmdb_ctrl through t_dp_cmd.
`timescale 1ns / 1ps

module cmdb_dp import cmdb_pkg::*; #(
    parameter int SLOTS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  t_in_item         i_item,
    input  t_dp_cmd          i_cmd,
    output t_dp_stat         o_stat,
    input  logic             i_stall,
    output logic             o_valid,
    output t_out_item        o_item
);

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int DEPTH  = 1 << SLOT_W;
    localparam logic [8:0] SLOTS_9 = 9'(SLOTS);

    logic [CFG_W-1:0]  r_active_slots;
    t_in_item          r_item;
    logic [CFG_W-1:0]  r_idx;
    logic [SLOT_W-1:0] r_idx_q;
    logic              r_q_vld;
    logic              r_used_q;
    logic [ID_W-1:0]   r_id_q;
    logic [DEPTH-1:0]  r_used;
    logic              r_wbank;
    logic [DEPTH-1:0]  r_bank_vld [2];
    t_out_item         r_rd_data;
    logic              r_rd_vld;
    t_out_item         r_out;
    logic              r_out_valid;

    logic [ID_W-1:0]   mem_ids  [DEPTH];
    t_out_item         mem_bank [2*DEPTH];

    logic [8:0]          w_count_9;
    logic [CFG_W-1:0]    w_count;
    logic [SLOT_W+7:0]   w_slot_ext;
    logic [SLOT_W+4:0]   w_idx_ext;
    logic [SLOT_W-1:0]   w_slot_addr;
    logic [SLOT_W-1:0]   w_idx_addr;
    logic                w_in_range;
    logic                w_at_end;
    t_out_item           w_frame;

    // effective slot count: register value clipped to SLOTS, never above 31
    assign w_count_9 = ({4'b0, r_active_slots} > SLOTS_9) ? SLOTS_9
                                                         : {4'b0, r_active_slots};
    assign w_count   = w_count_9[CFG_W-1:0];

    assign w_slot_ext  = {{SLOT_W{1'b0}}, r_item.slot};
    assign w_idx_ext   = {{SLOT_W{1'b0}}, r_idx};
    assign w_slot_addr = w_slot_ext[SLOT_W-1:0];
    assign w_idx_addr  = w_idx_ext[SLOT_W-1:0];

    assign w_in_range = ({3'b0, w_count} > r_item.slot);
    assign w_at_end   = (r_idx >= w_count);

    assign w_frame.read_id      = r_item.frame_id;
    assign w_frame.read_length  = (r_item.frame_length > MAX_LEN) ? MAX_LEN
                                                                  : r_item.frame_length;
    assign w_frame.read_payload = r_item.frame_payload;

    assign o_stat.command       = r_item.command;
    assign o_stat.slot_in_range = w_in_range;
    assign o_stat.idx_at_end    = w_at_end;
    assign o_stat.hit           = r_q_vld & r_used_q & (r_id_q == r_item.frame_id);
    assign o_stat.out_free      = !r_out_valid || !i_stall;

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_slots <= '0;
            r_used         <= '0;
            r_wbank        <= 1'b0;
            r_bank_vld[0]  <= '0;
            r_bank_vld[1]  <= '0;
            r_q_vld        <= 1'b0;
            r_idx          <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_active_slots <= i_cfg_data;
            end
            if (i_cmd.capture) begin
                r_idx   <= '0;
                r_q_vld <= 1'b0;
            end else if (i_cmd.probe) begin
                r_idx   <= r_idx + 1'b1;
                r_q_vld <= !w_at_end;
            end else begin
                r_q_vld <= 1'b0;
            end
            if (i_cmd.set_wr) begin
                r_used[w_slot_addr] <= 1'b1;
            end
            if (i_cmd.frame_wr) begin
                r_bank_vld[r_wbank][r_idx_q] <= 1'b1;
            end
            // swap empties the read bank, then it becomes the write bank
            if (i_cmd.swap) begin
                r_bank_vld[~r_wbank] <= '0;
                r_wbank              <= ~r_wbank;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_item;
        end
        if (i_cmd.probe) begin
            r_idx_q  <= w_idx_addr;
            r_used_q <= r_used[w_idx_addr];
        end
        if (i_cmd.bank_rd) begin
            r_rd_vld <= w_in_range & r_bank_vld[~r_wbank][w_slot_addr];
        end
        if (i_cmd.out_load) begin
            r_out <= r_rd_vld ? r_rd_data : '0;
        end
    end

    // filter identifier table
    always_ff @(posedge i_clk) begin
        if (i_cmd.set_wr) begin
            mem_ids[w_slot_addr] <= r_item.frame_id;
        end
        if (i_cmd.probe) begin
            r_id_q <= mem_ids[w_idx_addr];
        end
    end

    // frame banks, bank select is the top address bit
    always_ff @(posedge i_clk) begin
        if (i_cmd.frame_wr) begin
            mem_bank[{r_wbank, r_idx_q}] <= w_frame;
        end
        if (i_cmd.bank_rd) begin
            r_rd_data <= mem_bank[{~r_wbank, w_slot_addr}];
        end
    end

endmodule

[rtl/can_id_mailbox_double_buffer_top.sv]
// Top level of the double-buffered CAN identifier mailbox.
// Depends on cmdb_pkg, cmdb_ctrl and cmdb_dp.
`timescale 1ns / 1ps

// CAN mailbox with SLOTS identifier filter slots and two frame banks. One item
// is handled at a time. Set and swap items pass through the decode state and
// return to idle; a read item then waits in the response state for the output
// register to empty; a frame item enters the filter search, which walks the
// identifier table one slot per cycle through its single read port, the compare
// runs on the registered probe result, and the search stops at the first
// match, so the number of slots probed is at most active_slots clipped to SLOTS.
// Bank contents are tracked with per-entry valid flags, so reset and swap need
// no clearing pass. The active_slots register may only be written while idle.

module can_id_mailbox_double_buffer_top import cmdb_pkg::*; #(
    parameter int SLOTS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_valid,
    output logic             o_stall,
    input  t_in_item         i_item,
    output logic             o_valid,
    input  logic             i_stall,
    output t_out_item        o_item
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    cmdb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    cmdb_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_item     (i_item),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .i_stall    (i_stall),
        .o_valid    (o_valid),
        .o_item     (o_item)
    );

endmodule
